// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int ID_W         = 16;
   localparam int PRIO_W       = 16;
   localparam int CMD_W        = 3;
   localparam int OCC_W        = 5;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FRONT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NUDGE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT_L,
      ST_LOCATE,
      ST_SHIFT_R,
      ST_PUT,
      ST_SWAP_RD,
      ST_SWAP_LO,
      ST_SWAP_HI,
      ST_HEAD_RD,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [ID_W-1:0]          item_id;
      logic signed [PRIO_W-1:0] item_priority;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   head_id;
      logic              head_valid;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic id_hit;
      logic prio_le;
   } cmp_type;

endpackage

// File: src/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/spq_cmp.sv
// ----------------------------------------------------------------------------
// spq_cmp
// Shared compare unit: id match and signed priority order against one entry.
// ----------------------------------------------------------------------------
module spq_cmp (
   input  logic [spq_pkg::ID_W-1:0]          key_id,
   input  logic signed [spq_pkg::PRIO_W-1:0] key_prio,
   input  spq_pkg::entry_type                entry,
   output spq_pkg::cmp_type                  result
);
   import spq_pkg::*;

   always_comb begin
      result.id_hit  = (entry.id == key_id);
      result.prio_le = (entry.prio <= key_prio);
   end

endmodule

// File: src/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue kept as a sorted array in one RAM; equal priorities
// keep arrival order. A small sequencer walks the RAM one entry per cycle.
// ----------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy, req_item          | beat taken when start & !busy
//  response | rsp_strobe, rsp_item           | one-cycle strobe, no backpressure
//
//  Steps per command: front, clear and unused codes read the head; dequeue
//  shifts down; nudge searches and swaps; enqueue searches, shifts out a
//  present id, then searches and shifts to insert. The single RAM read port
//  walks one entry per cycle. busy is high from the accepted beat until the
//  response strobe. Reset empties the queue; the RAM itself is never cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_item
);
   import spq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int EW = $bits(entry_type);

   state_type  state_ff, state_in;
   req_type    req_ff, req_in;
   status_type status_ff, status_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   logic [IW-1:0] count_ff, count_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic       pend_ff, pend_in;
   entry_type  hold_ff, hold_in;

   logic          accept;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_entry;
   logic [EW-1:0] rd_raw;
   cmp_type       cmp;

   logic [IW-1:0] scan_inc1, scan_dec1, scan_dec2, scan_add1, pos_dec1;
   logic          scan_lt_cnt, scan_gt_pos, hit_now, above_now, full, empty;

   spq_ram #(
      .WIDTH(EW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   spq_cmp u_cmp (
      .key_id   (req_ff.item_id),
      .key_prio (req_ff.item_priority),
      .entry    (rd_entry),
      .result   (cmp)
   );

   assign accept      = start && (state_ff == ST_IDLE);
   assign scan_inc1   = scan_ff + IW'(1);
   assign scan_add1   = scan_ff + IW'(1);
   assign scan_dec1   = scan_ff - IW'(1);
   assign scan_dec2   = scan_ff - IW'(2);
   assign pos_dec1    = pos_ff - IW'(1);
   assign scan_lt_cnt = (scan_ff < count_ff);
   assign scan_gt_pos = (scan_ff > pos_ff);
   assign hit_now     = pend_ff && cmp.id_hit;
   assign above_now   = pend_ff && !cmp.prio_le;
   assign full        = (count_ff >= IW'(CAPACITY));
   assign empty       = (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_ENQUEUE || req_item.command == CMD_NUDGE) begin
                  state_in = ST_FIND;
               end else if (req_item.command == CMD_DEQUEUE && !empty) begin
                  state_in = ST_SHIFT_L;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end
         ST_FIND: begin
            if (hit_now) begin
               if (req_ff.command == CMD_ENQUEUE) begin
                  state_in = ST_SHIFT_L;
               end else if (scan_ff == IW'(1)) begin
                  state_in = ST_HEAD_RD;  // already at the front
               end else begin
                  state_in = ST_SWAP_RD;
               end
            end else if (!scan_lt_cnt) begin
               if (req_ff.command == CMD_ENQUEUE && !full) begin
                  state_in = ST_LOCATE;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end
         ST_SHIFT_L: begin
            if (!scan_lt_cnt && !pend_ff) begin
               state_in = (req_ff.command == CMD_ENQUEUE) ? ST_LOCATE : ST_HEAD_RD;
            end
         end
         ST_LOCATE: begin
            if (above_now || !scan_lt_cnt) begin
               state_in = ST_SHIFT_R;
            end
         end
         ST_SHIFT_R: begin
            if (!scan_gt_pos && !pend_ff) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT:     state_in = ST_HEAD_RD;
         ST_SWAP_RD: state_in = ST_SWAP_LO;
         ST_SWAP_LO: state_in = ST_SWAP_HI;
         ST_SWAP_HI: state_in = ST_HEAD_RD;
         ST_HEAD_RD: state_in = ST_REPLY;
         ST_REPLY:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      status_in     = status_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      hold_in       = hold_ff;
      rd_addr       = scan_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pos_ff[AW-1:0];
      wr_data       = hold_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in    = req_item;
               status_in = STAT_OK;
               pos_in    = '0;
               pend_in   = 1'b0;
               scan_in   = (req_item.command == CMD_DEQUEUE) ? IW'(1) : '0;
               if ((req_item.command == CMD_DEQUEUE || req_item.command == CMD_FRONT)
                   && empty) begin
                  status_in = STAT_EMPTY;
               end
               if (req_item.command == CMD_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_FIND: begin
            if (hit_now) begin
               pos_in  = scan_dec1;
               pend_in = 1'b0;       // scan already points one past the hit
            end else if (scan_lt_cnt) begin
               scan_in = scan_inc1;
               pend_in = 1'b1;
            end else begin
               scan_in = '0;
               pend_in = 1'b0;
               if (req_ff.command == CMD_ENQUEUE) begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_SHIFT_L: begin
            // rd data holds entry scan-1, it moves down to scan-2
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = scan_dec2[AW-1:0];
               wr_data = rd_entry;
            end
            if (scan_lt_cnt) begin
               scan_in = scan_inc1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - IW'(1);
                  scan_in  = '0;
               end
            end
         end
         ST_LOCATE: begin
            if (above_now) begin
               pos_in  = scan_dec1;
               scan_in = count_ff;
               pend_in = 1'b0;
            end else if (scan_lt_cnt) begin
               scan_in = scan_inc1;
               pend_in = 1'b1;
            end else begin
               pos_in  = count_ff;
               scan_in = count_ff;
               pend_in = 1'b0;
            end
         end
         ST_SHIFT_R: begin
            // rd data holds entry scan, it moves up to scan+1
            rd_addr = scan_dec1[AW-1:0];
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = scan_add1[AW-1:0];
               wr_data = rd_entry;
            end
            if (scan_gt_pos) begin
               scan_in = scan_dec1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff[AW-1:0];
            wr_data.id   = req_ff.item_id;
            wr_data.prio = req_ff.item_priority;
            count_in     = count_ff + IW'(1);
         end
         ST_SWAP_RD: begin
            rd_addr = pos_dec1[AW-1:0];
         end
         ST_SWAP_LO: begin
            wr_en        = 1'b1;
            wr_addr      = pos_dec1[AW-1:0];
            wr_data.id   = req_ff.item_id;
            wr_data.prio = rd_entry.prio;
            hold_in      = rd_entry;
         end
         ST_SWAP_HI: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = hold_ff;
         end
         ST_HEAD_RD: begin
            rd_addr = '0;
         end
         ST_REPLY: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.status     = status_ff;
            rsp_in.head_id    = empty ? '0 : rd_entry.id;
            rsp_in.head_valid = !empty;
            rsp_in.occupancy  = OCC_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
      scan_ff   <= scan_in;
      pos_ff    <= pos_in;
      hold_ff   <= hold_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stable_priority_queue_top. A queue of command beats
// is built up front, both directed corner cases and random bursts. A clocked
// driver issues them, with random gaps in the first two thirds, and predicts
// each response from a behavioral copy of the sorted queue. A clocked monitor
// checks every response strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = CAPACITY_DEF;
   localparam int N_ITEMS      = 1700;
   localparam int ID_POOL      = 28;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   // codes the block decodes as no-ops
   localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   stable_priority_queue_top #(.CAPACITY(QUEUE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #2 clock = ~clock;

   // shadow copy of the queue contents
   entry_type       held [QUEUE_DEPTH];
   int              held_count = 0;

   req_type         pending_beats [$];
   rsp_type         expected_rsps [$];
   logic [ID_W-1:0] id_pool [ID_POOL];
   rsp_type         want_rsp;
   int              n_total      = 0;
   int              n_sent       = 0;
   int              n_rsps       = 0;
   int              n_errors     = 0;
   int              quiet_cycles = 0;
   int              status_seen [4] = '{0, 0, 0, 0};

   // ---------------------------------------------------------------- model
   function automatic int find_held(logic [ID_W-1:0] id);
      for (int i = 0; i < held_count; i++)
         if (held[i].id == id) return i;
      return -1;
   endfunction

   function automatic void remove_held(int pos);
      for (int i = pos; i + 1 < held_count; i++) held[i] = held[i + 1];
      held_count--;
   endfunction

   // goes after every entry of lower or equal priority
   function automatic void insert_held(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      int pos = 0;
      while (pos < held_count && $signed(held[pos].prio) <= $signed(prio)) pos++;
      for (int i = held_count; i > pos; i--) held[i] = held[i - 1];
      held[pos].id   = id;
      held[pos].prio = prio;
      held_count++;
   endfunction

   function automatic rsp_type apply_command(req_type r);
      rsp_type         o;
      int              pos;
      logic [ID_W-1:0] prev_id;
      o.status = STAT_OK;
      case (r.command)
         CMD_ENQUEUE: begin
            pos = find_held(r.item_id);
            if (pos >= 0) begin
               remove_held(pos);
               insert_held(r.item_id, r.item_priority);
            end else if (held_count >= QUEUE_DEPTH) begin
               o.status = STAT_FULL;
            end else begin
               insert_held(r.item_id, r.item_priority);
            end
         end
         CMD_DEQUEUE: begin
            if (held_count == 0) o.status = STAT_EMPTY;
            else remove_held(0);
         end
         CMD_FRONT: begin
            if (held_count == 0) o.status = STAT_EMPTY;
         end
         CMD_NUDGE: begin
            pos = find_held(r.item_id);
            if (pos < 0) begin
               o.status = STAT_NOT_FOUND;
            end else if (pos > 0) begin
               // swap with predecessor; both keep the predecessor's priority
               prev_id           = held[pos - 1].id;
               held[pos].prio    = held[pos - 1].prio;
               held[pos - 1].id  = held[pos].id;
               held[pos].id      = prev_id;
            end
         end
         CMD_CLEAR: held_count = 0;
         default: ;
      endcase
      o.head_valid = (held_count > 0);
      o.head_id    = (held_count > 0) ? held[0].id : '0;
      o.occupancy  = OCC_W'(held_count);
      return o;
   endfunction

   // ------------------------------------------------------------- stimulus
   task automatic add_beat(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [PRIO_W-1:0] prio);
      req_type r;
      r.command       = cmd;
      r.item_id       = id;
      r.item_priority = prio;
      pending_beats.push_back(r);
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 85) return id_pool[$urandom_range(ID_POOL - 1)];
      return ID_W'($urandom_range(16'hFFFF));
   endfunction

   // most often a narrow band so ties are common, plus extremes and full range
   function automatic logic [PRIO_W-1:0] pick_prio();
      int r = $urandom_range(99);
      if (r < 45) return PRIO_W'(int'($urandom_range(4)) - 2);
      if (r < 60) begin
         case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'h0000;
         endcase
      end
      return PRIO_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd();
      int r = $urandom_range(99);
      if (r < 42) return CMD_ENQUEUE;
      if (r < 57) return CMD_DEQUEUE;
      if (r < 65) return CMD_FRONT;
      if (r < 90) return CMD_NUDGE;
      if (r < 93) return CMD_CLEAR;
      return CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
   endfunction

   function automatic int idle_percent();
      if (n_sent < n_total / 3) return 11;
      if (n_sent < 2 * n_total / 3) return 84;
      return 0;
   endfunction

   // --------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_command(req_item));
            n_sent++;
         end
         if (!start || !busy) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= idle_percent()) begin
               req_item <= pending_beats.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor
   task automatic flag_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      n_errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_rsps++;
         if (expected_rsps.size() == 0) begin
            flag_error("response beat with nothing outstanding");
         end else begin
            want_rsp = expected_rsps.pop_front();
            status_seen[want_rsp.status]++;
            if (rsp_item.status !== want_rsp.status)
               flag_error($sformatf("rsp %0d status %0d, want %0d", n_rsps,
                                    rsp_item.status, want_rsp.status));
            if (rsp_item.head_id !== want_rsp.head_id)
               flag_error($sformatf("rsp %0d head_id %h, want %h", n_rsps,
                                    rsp_item.head_id, want_rsp.head_id));
            if (rsp_item.head_valid !== want_rsp.head_valid)
               flag_error($sformatf("rsp %0d head_valid %b, want %b", n_rsps,
                                    rsp_item.head_valid, want_rsp.head_valid));
            if (rsp_item.occupancy !== want_rsp.occupancy)
               flag_error($sformatf("rsp %0d occupancy %0d, want %0d", n_rsps,
                                    rsp_item.occupancy, want_rsp.occupancy));
         end
      end
   end

   // ------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("TIMEOUT: no beat moved for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ----------------------------------------------------------------- main
   initial begin
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom_range(16'hFFFF));

      // directed: empty queue, extremes, ties, nudge corners, no-op codes
      add_beat(CMD_DEQUEUE, 16'h0000, 16'h0000);
      add_beat(CMD_FRONT,   16'hFFFF, 16'hFFFF);
      add_beat(CMD_NUDGE,   16'h0007, 16'h0000);
      add_beat(CMD_ENQUEUE, 16'hFFFF, 16'h7FFF);
      add_beat(CMD_ENQUEUE, 16'h0000, 16'h8000);
      add_beat(CMD_ENQUEUE, 16'h0005, 16'h7FFF);  // tie, lands behind FFFF
      add_beat(CMD_FRONT,   16'h0000, 16'h0000);
      add_beat(CMD_NUDGE,   16'h0005, 16'h0000);
      add_beat(CMD_NUDGE,   16'h0000, 16'h0000);  // already at head
      add_beat(CMD_NUDGE,   16'h1234, 16'h0000);  // absent id
      add_beat(CMD_ENQUEUE, 16'hFFFF, 16'h8000);  // present id, re-inserted
      for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
         add_beat(CMD_W'(c), 16'hA5A5, 16'h5A5A);
      add_beat(CMD_DEQUEUE, 16'h0000, 16'h0000);
      add_beat(CMD_CLEAR,   16'h0000, 16'h0000);
      add_beat(CMD_FRONT,   16'h0000, 16'h0000);

      // random bursts: fills that hit the full case, drains, mixed traffic
      while (pending_beats.size() < N_ITEMS) begin
         case ($urandom_range(99) / 10)
            0, 1, 2:
               repeat ($urandom_range(26, 18)) add_beat(CMD_ENQUEUE, pick_id(), pick_prio());
            3:
               repeat ($urandom_range(20, 10)) add_beat(CMD_DEQUEUE, pick_id(), pick_prio());
            default:
               repeat (20) add_beat(pick_cmd(), pick_id(), pick_prio());
         endcase
      end
      n_total = pending_beats.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (n_sent == n_total && expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands issued, %0d responses checked, %0d mismatches",
               n_sent, n_rsps, n_errors);
      $display("statuses seen: ok %0d, empty %0d, not found %0d, full %0d",
               status_seen[STAT_OK], status_seen[STAT_EMPTY],
               status_seen[STAT_NOT_FOUND], status_seen[STAT_FULL]);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
